### hdl/slc_pkg.sv
// Shared types and constants of the set-associative LRU cache tag store.
// Used by slc_front, slc_back and set_assoc_lru_cache_tags_core.
`default_nettype none

package slc_pkg;

	localparam int ADDR_W          = 32;
	localparam int PAGE_W          = 20;
	localparam int STAMP_W         = 32;
	localparam int SET_OUT_W       = 6;
	localparam int TAG_OUT_W       = 20;
	localparam int IN_DATA_W       = 56;
	localparam int OUT_DATA_W      = 32;
	localparam int ACTION_W        = 2;
	localparam int OFFSET_BITS_DEF = 6;
	localparam int INDEX_BITS_DEF  = 6;
	localparam int WAYS_DEF        = 4;

	typedef enum logic [ACTION_W-1:0] {
		ACT_READ     = 2'd0,
		ACT_INV_ADDR = 2'd1,
		ACT_INV_PAGE = 2'd2,
		ACT_NONE     = 2'd3
	} action_t;

	// One request word between the front and the back, with its effective address.
	typedef struct packed {
		action_t             action;
		logic [ADDR_W-1:0]   addr;
	} req_t;

	// Result word, hit in the lowest bit.
	typedef struct packed {
		logic [2:0]           pad;
		logic                 forward_invalidate;
		logic                 memory_access;
		logic [TAG_OUT_W-1:0] line_tag;
		logic [SET_OUT_W-1:0] set_index;
		logic                 hit;
	} res_t;

endpackage

`default_nettype wire

### hdl/slc_front.sv
// Front end of the tag store: accepts input words, forms the effective address
// and holds them in a two-entry queue for the back end. Depends on slc_pkg.
`default_nettype none

module slc_front
	import slc_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_DATA_W-1:0] s_tdata,
	input  wire logic [ACTION_W-1:0]  s_tuser,
	output logic                      req_valid,
	output req_t                      req,
	input  wire logic                 req_pop
);

	localparam int SHIFT = OFFSET_BITS + INDEX_BITS;

	req_t             queue_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             push;
	logic             pop;
	logic [ADDR_W-1:0] page_ext;
	req_t             in_req;

	assign s_tready  = (count_q != 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign req       = queue_q[rd_ptr_q];
	assign push      = s_tvalid && s_tready;
	assign pop       = req_pop && req_valid;

	always_comb begin
		page_ext      = {{(ADDR_W - PAGE_W){1'b0}}, s_tdata[ADDR_W +: PAGE_W]};
		in_req.action = action_t'(s_tuser);
		if (in_req.action == ACT_INV_PAGE) begin
			in_req.addr = page_ext << SHIFT;
		end else begin
			in_req.addr = s_tdata[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/slc_back.sv
// Back end of the tag store: tag and stamp memories, hit and victim logic,
// stamp counter and the registered result word. Depends on slc_pkg.
`default_nettype none

module slc_back
	import slc_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int WAYS        = WAYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  use_second_level,
	input  wire logic                  req_valid,
	input  wire req_t                  req,
	output logic                       req_pop,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int SHIFT = OFFSET_BITS + INDEX_BITS;
	localparam int SET_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
	localparam int SETS  = 2 ** SET_W;
	localparam int TAG_W = ADDR_W - SHIFT;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << INDEX_BITS) - 64'd1);

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t              state_q;
	action_t             act_q;
	logic [SET_W-1:0]    set_q;
	logic [TAG_W-1:0]    tag_q;
	logic [STAMP_W-1:0]  stamp_cnt_q;
	logic                out_valid_q;
	res_t                out_res_q;
	logic [WAYS-1:0]     line_valid_q [SETS];
	logic [WAYS-1:0]     stamped_q [SETS];

	logic [TAG_W-1:0]    tag_mem [SETS][WAYS];
	logic [STAMP_W-1:0]  stamp_mem [SETS][WAYS];
	logic [TAG_W-1:0]    tag_rd_q [WAYS];
	logic [STAMP_W-1:0]  stamp_rd_q [WAYS];

	logic                rd_en;
	logic [ADDR_W-1:0]   head_set_full;
	logic [ADDR_W-1:0]   head_tag_full;
	logic [SET_W-1:0]    rd_set;
	logic                hit_any;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    victim;
	logic [STAMP_W-1:0]  eff_stamp [WAYS];
	logic [WAY_W-1:0]    way_sel;
	logic                go;
	logic                is_read;
	logic                is_inv;
	logic                tag_we;
	logic                stamp_we;
	logic [ADDR_W-1:0]   set_ext;
	logic [ADDR_W-1:0]   tag_ext;
	res_t                res;

	assign req_pop       = (state_q == ST_IDLE);
	assign rd_en         = req_pop && req_valid;
	assign head_set_full = (req.addr >> OFFSET_BITS) & SET_MASK;
	assign head_tag_full = req.addr >> SHIFT;
	assign rd_set        = head_set_full[SET_W-1:0];
	assign m_tvalid      = out_valid_q;
	assign m_tdata       = out_res_q;

	assign go       = (state_q == ST_LOOK) && (!out_valid_q || m_tready);
	assign is_read  = (act_q == ACT_READ);
	assign is_inv   = (act_q == ACT_INV_ADDR) || (act_q == ACT_INV_PAGE);
	assign way_sel  = hit_any ? hit_way : victim;
	assign tag_we   = go && is_read && !hit_any;
	assign stamp_we = go && is_read;

	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (line_valid_q[set_q][w] && (tag_rd_q[w] == tag_q)) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			eff_stamp[w] = stamped_q[set_q][w] ? stamp_rd_q[w] : '0;
		end
		victim = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (eff_stamp[w] < eff_stamp[victim]) begin
				victim = WAY_W'(w);
			end
		end
	end

	always_comb begin
		set_ext                = {{(ADDR_W - SET_W){1'b0}}, set_q};
		tag_ext                = {{SHIFT{1'b0}}, tag_q};
		res                    = '0;
		if (is_read || is_inv) begin
			res.hit                = hit_any;
			res.set_index          = set_ext[SET_OUT_W-1:0];
			res.line_tag           = tag_ext[TAG_OUT_W-1:0];
			res.memory_access      = is_read && !hit_any && !use_second_level;
			res.forward_invalidate = is_inv && hit_any && use_second_level;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int w = 0; w < WAYS; w++) begin
				tag_rd_q[w]   <= tag_mem[rd_set][w];
				stamp_rd_q[w] <= stamp_mem[rd_set][w];
			end
		end
		if (tag_we) begin
			tag_mem[set_q][way_sel] <= tag_q;
		end
		if (stamp_we) begin
			stamp_mem[set_q][way_sel] <= stamp_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= ACT_NONE;
			set_q       <= '0;
			tag_q       <= '0;
			stamp_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
			for (int s = 0; s < SETS; s++) begin
				line_valid_q[s] <= '0;
				stamped_q[s]    <= '0;
			end
		end else begin
			if (m_tready && !go) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						act_q   <= req.action;
						set_q   <= rd_set;
						tag_q   <= head_tag_full[TAG_W-1:0];
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (go) begin
						out_valid_q <= 1'b1;
						out_res_q   <= res;
						if (is_read) begin
							line_valid_q[set_q][way_sel] <= 1'b1;
							stamped_q[set_q][way_sel]    <= 1'b1;
							stamp_cnt_q                  <= stamp_cnt_q + 1'b1;
						end else if (is_inv && hit_any) begin
							line_valid_q[set_q][hit_way] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/set_assoc_lru_cache_tags_core.sv
// Top level of the set-associative cache tag store with timestamp LRU.
// Instantiates slc_front and slc_back; depends on slc_pkg.
//
// Usage: input words arrive on s_tvalid/s_tready with the action code in
// s_tuser and the address and page number in s_tdata. Each input word gives
// exactly one result word on m_tvalid/m_tready, in order. A read either hits
// and refreshes the way's stamp, or misses and installs the tag in the way
// with the oldest stamp. Invalidates clear a matching valid line.
// The use_second_level register is written over cfg_valid/cfg_data; the user must
// write it only while the block is idle; the block does not enforce this. cfg_ready
// is always high. Each word passes the queue, the tag and stamp read registers and
// the result register. The back end reads the set's tag and stamp row in ST_IDLE,
// compares the ways, picks the victim and writes back in ST_LOOK, and takes no new
// word until it is through with the last. A two-entry queue lets input words be
// taken while the back end works, and the result register lets the next word
// proceed while a result waits. When the receiver stalls the result is held, the
// back end waits, and s_tready drops once the queue is full.
// Reset clears all valid bits, stamps, the stamp counter and the register.
`default_nettype none

module set_assoc_lru_cache_tags_core
	import slc_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int INDEX_BITS  = INDEX_BITS_DEF,
	parameter int WAYS        = WAYS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic                  cfg_data,      // use_second_level
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,       // address, page_number, zero fill
	input  wire logic [ACTION_W-1:0]   s_tuser,       // action
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata        // hit, set_index, line_tag,
	                                                  // memory_access, forward_invalidate,
	                                                  // zero fill
);

	logic use_second_level_q;
	logic req_valid;
	req_t req;
	logic req_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_second_level_q <= 1'b0;
		end else if (cfg_valid) begin
			use_second_level_q <= cfg_data;
		end
	end

	slc_front #(
		.OFFSET_BITS (OFFSET_BITS),
		.INDEX_BITS  (INDEX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	slc_back #(
		.OFFSET_BITS (OFFSET_BITS),
		.INDEX_BITS  (INDEX_BITS),
		.WAYS        (WAYS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.use_second_level (use_second_level_q),
		.req_valid        (req_valid),
		.req              (req),
		.req_pop          (req_pop),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata)
	);

	// A read that hits never also requests main memory.
	a_hit_no_mem: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[27]))
		else $error("hit and memory_access both set");

	// Forwarding and memory access belong to different actions.
	a_mem_fwd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[27] && m_tdata[28]))
		else $error("memory_access and forward_invalidate both set");

	// Forwarding only happens with a second level behind, memory access only without.
	a_fwd_l2: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[28]) |-> use_second_level_q)
		else $error("forward_invalidate without second level");

	a_mem_no_l2: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[27]) |-> !use_second_level_q)
		else $error("memory_access with second level present");

endmodule

`default_nettype wire

### verif/slc_tag_checker.sv
// Checker for the set-associative LRU cache tag store: watches the config,
// input and result channels, predicts each result word and compares it.
// Depends on slc_pkg for the word layouts, the action codes and the sizes.
`default_nettype none

module slc_tag_checker
	import slc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic                  cfg_data,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [ACTION_W-1:0]   s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	output int                         results_due,
	output int                         fail_count
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETS  = 1 << INDEX_BITS_DEF;
	localparam int LINES = SETS * WAYS_DEF;
	localparam int LOW_BITS = OFFSET_BITS_DEF + INDEX_BITS_DEF;

	logic                 way_valid [LINES];
	logic [TAG_OUT_W-1:0] way_tag   [LINES];
	logic [STAMP_W-1:0]   way_stamp [LINES];
	logic [STAMP_W-1:0]   stamp_now;
	logic                 use_l2;
	res_t                 expected_results [$];
	int                   mismatches;

	assign results_due = expected_results.size();
	assign fail_count  = mismatches;

	function automatic res_t lookup_tags(action_t act, logic [ADDR_W-1:0] addr,
			logic [PAGE_W-1:0] page);
		res_t                 r;
		logic [ADDR_W-1:0]    eff;
		logic [TAG_OUT_W-1:0] tag;
		int                   base;
		int                   found;
		int                   victim;
		r = '0;
		if (act == ACT_NONE)
			return r;
		eff = (act == ACT_INV_PAGE) ? (ADDR_W'(page) << LOW_BITS) : addr;
		tag = TAG_OUT_W'(eff >> LOW_BITS);
		r.set_index = SET_OUT_W'(eff >> OFFSET_BITS_DEF);
		r.line_tag  = tag;
		base  = int'(r.set_index) * WAYS_DEF;
		found = -1;
		for (int w = 0; w < WAYS_DEF; w++) begin
			if (found < 0 && way_valid[base + w] && way_tag[base + w] == tag)
				found = w;
		end
		if (act == ACT_READ) begin
			if (found >= 0) begin
				r.hit = 1'b1;
				way_stamp[base + found] = stamp_now;
			end else begin
				r.memory_access = !use_l2;
				victim = 0;
				for (int w = 1; w < WAYS_DEF; w++) begin
					if (way_stamp[base + w] < way_stamp[base + victim])
						victim = w;
				end
				way_valid[base + victim] = 1'b1;
				way_tag[base + victim]   = tag;
				way_stamp[base + victim] = stamp_now;
			end
			stamp_now = stamp_now + 1'b1;
		end else if (found >= 0) begin
			r.hit = 1'b1;
			r.forward_invalidate = use_l2;
			way_valid[base + found] = 1'b0;
		end
		return r;
	endfunction

	task automatic compare_field(string name, longint unsigned exp_val,
			longint unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t exp_word;
		res_t got_word;
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				way_valid[i] = 1'b0;
				way_tag[i]   = '0;
				way_stamp[i] = '0;
			end
			stamp_now = '0;
			use_l2 = 1'b0;
			expected_results.delete();
			mismatches = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				use_l2 = cfg_data;
			if (m_tvalid && m_tready) begin
				got_word = res_t'(m_tdata);
				if (expected_results.size() == 0) begin
					$error("result word 0x%0h arrived with no expectation waiting", m_tdata);
					mismatches++;
				end else begin
					exp_word = expected_results.pop_front();
					compare_field("hit", exp_word.hit, got_word.hit);
					compare_field("set_index", exp_word.set_index, got_word.set_index);
					compare_field("line_tag", exp_word.line_tag, got_word.line_tag);
					compare_field("memory_access", exp_word.memory_access,
						got_word.memory_access);
					compare_field("forward_invalidate", exp_word.forward_invalidate,
						got_word.forward_invalidate);
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(lookup_tags(action_t'(s_tuser),
					s_tdata[ADDR_W-1:0], s_tdata[ADDR_W +: PAGE_W]));
		end
	end

endmodule

`default_nettype wire

### verif/tb.sv
// Top of the cache tag store testbench: clock, reset, stimulus and verdict.
// Instantiates set_assoc_lru_cache_tags_core and slc_tag_checker; uses slc_pkg.
`default_nettype none

module tb;

	import slc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [ACTION_W-1:0]   s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    results_due;
	int                    fail_count;
	logic                  quiet;
	logic [TAG_OUT_W-1:0]  tag_pool [8];
	logic [SET_OUT_W-1:0]  set_pool [4];

	set_assoc_lru_cache_tags_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	slc_tag_checker tag_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.results_due (results_due),
		.fail_count  (fail_count)
	);

	always #5 clk = ~clk;

	initial begin
		#3_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14) - 1) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(0, 24)) @(negedge clk);
			end
		end
	end

	function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_OUT_W-1:0] tag,
			logic [SET_OUT_W-1:0] set_no, logic [OFFSET_BITS_DEF-1:0] offset);
		return {tag, set_no, offset};
	endfunction

	task automatic send_word(action_t act, logic [ADDR_W-1:0] addr, logic [PAGE_W-1:0] page);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {{(IN_DATA_W - ADDR_W - PAGE_W){1'b0}}, page, addr};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic hold_off(int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
	endtask

	task automatic write_l2_mode(logic value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_word;
		action_t              act;
		logic [ADDR_W-1:0]    addr;
		logic [PAGE_W-1:0]    page;
		int unsigned          pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			act = ACT_READ;
		else if (pick < 72)
			act = ACT_INV_ADDR;
		else if (pick < 92)
			act = ACT_INV_PAGE;
		else
			act = ACT_NONE;
		if ($urandom_range(0, 99) < 85)
			addr = line_addr(tag_pool[$urandom_range(0, 7)], set_pool[$urandom_range(0, 3)],
				OFFSET_BITS_DEF'($urandom));
		else
			addr = $urandom;
		if (act == ACT_INV_PAGE && $urandom_range(0, 99) < 85)
			page = tag_pool[$urandom_range(0, 7)];
		else
			page = PAGE_W'($urandom);
		send_word(act, addr, page);
	endtask

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = ACT_READ;
		quiet     = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_l2_mode(1'b0);
		send_word(ACT_READ, 32'h0000_0000, 20'h00000);
		send_word(ACT_READ, 32'h0000_0000, 20'hFFFFF);
		send_word(ACT_READ, 32'hFFFF_FFFF, 20'hFFFFF);
		send_word(ACT_READ, 32'hFFFF_FFC0, 20'h00000);
		for (int t = 1; t <= 5; t++)
			send_word(ACT_READ, line_addr(TAG_OUT_W'(t), 6'd1, 6'd0), 20'h00000);
		send_word(ACT_READ, line_addr(20'd2, 6'd1, 6'd63), 20'h00000);
		send_word(ACT_INV_ADDR, line_addr(20'd3, 6'd1, 6'd5), 20'hFFFFF);
		send_word(ACT_INV_ADDR, line_addr(20'd3, 6'd1, 6'd5), 20'h00000);
		send_word(ACT_READ, line_addr(20'd6, 6'd1, 6'd0), 20'h00000);
		send_word(ACT_INV_PAGE, 32'hFFFF_FFFF, 20'h00000);
		send_word(ACT_INV_PAGE, 32'h0000_0000, 20'hFFFFF);
		send_word(ACT_NONE, 32'hFFFF_FFFF, 20'hFFFFF);
		send_word(ACT_INV_ADDR, 32'hFFFF_FFFF, 20'hFFFFF);
		drain;
		write_l2_mode(1'b1);
		send_word(ACT_READ, 32'h1234_5678, 20'h00000);
		send_word(ACT_READ, 32'h1234_5678, 20'h00000);
		send_word(ACT_INV_ADDR, 32'h1234_5678, 20'h00000);
		send_word(ACT_READ, 32'hABCD_E000, 20'h00000);
		send_word(ACT_INV_PAGE, 32'h0000_0000, 20'hABCDE);
		send_word(ACT_NONE, 32'h0000_0000, 20'h00000);

		for (int phase = 0; phase < 4; phase++) begin
			drain;
			write_l2_mode(phase[0]);
			tag_pool[0] = '0;
			tag_pool[1] = '1;
			for (int i = 2; i < 8; i++)
				tag_pool[i] = TAG_OUT_W'($urandom);
			set_pool[0] = '0;
			set_pool[1] = '1;
			set_pool[2] = SET_OUT_W'($urandom);
			set_pool[3] = SET_OUT_W'($urandom);
			for (int n = 0; n < 500; n++) begin
				if (phase == 3 && n == 300)
					quiet = 1'b1;
				if (!quiet && $urandom_range(0, 9) == 0)
					hold_off($urandom_range(1, 14));
				random_word();
			end
		end

		drain;
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire
